/* rtl/sbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants for the SACK block composer
// Option sizes, result record layout and the result-queue geometry.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int unsigned MAX_RANGES_DEF = 4;
  localparam int unsigned HEADER_BYTES   = 2;
  localparam int unsigned PAIR_BYTES     = 8;

  // result queue, depth must be a power of two and at least 2
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

  typedef struct packed {
    logic [31:0] seg_start;
    logic [15:0] seg_length;
    logic        first_item;
    logic        last_item;
    logic [7:0]  space_bytes;
  } seg_t;

  typedef struct packed {
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        range_valid;
    logic        run_done;
    logic        composed;
    logic [7:0]  option_bytes;
    logic [7:0]  space_left;
  } res_t;

  // results produced by one segment transfer: cnt of 0, 1 or 2, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] option_len(input logic [2:0] ranges);
    return 8'(HEADER_BYTES) + 8'(PAIR_BYTES) * {5'd0, ranges};
  endfunction

endpackage
`default_nettype wire

/* rtl/sbc_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_seg_if / sbc_res_if: valid/ready channels of the SACK block composer
// Segment descriptor channel in, SACK range result channel out.
// ----------------------------------------------------------------------------
interface sbc_seg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seg_start;
  logic [15:0] seg_length;
  logic        first_item;
  logic        last_item;
  logic [7:0]  space_bytes;

  modport source (output valid, seg_start, seg_length, first_item, last_item, space_bytes,
                  input ready);
  modport sink   (input valid, seg_start, seg_length, first_item, last_item, space_bytes,
                  output ready);
endinterface

interface sbc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic        range_valid;
  logic        run_done;
  logic        composed;
  logic [7:0]  option_bytes;
  logic [7:0]  space_left;

  modport source (output valid, range_start, range_end, range_valid, run_done, composed,
                  option_bytes, space_left, input ready);
  modport sink   (input valid, range_start, range_end, range_valid, run_done, composed,
                  option_bytes, space_left, output ready);
endinterface
`default_nettype wire

/* rtl/sbc_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_step: per-segment range merge and option accounting
// Holds the open range and byte/block budget; emits up to two results per
// accepted segment (closed gap range, then the done record).
// ----------------------------------------------------------------------------
module sbc_step #(
  parameter int unsigned MAX_RANGES = sbc_pkg::MAX_RANGES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          seg_vld,
  input  sbc_pkg::seg_t seg,
  output sbc_pkg::push_t push
);
  import sbc_pkg::*;

  logic [31:0] range_left_r, range_left_nxt;
  logic [31:0] range_right_r, range_right_nxt;
  logic [2:0]  ranges_emitted_r, ranges_emitted_nxt;
  logic [7:0]  bytes_free_r, bytes_free_nxt;
  logic        halted_r, halted_nxt;
  logic        aborted_r, aborted_nxt;

  logic [31:0] seg_end;
  logic        exh_cur, exh_mid, gap;
  logic [31:0] rl_mid, rr_mid;
  logic [2:0]  re_mid, re_fin;
  logic [7:0]  bf_mid, bf_fin;
  logic        halted_mid, aborted_mid;
  res_t        gap_res, done_res;

  always_comb begin
    seg_end = seg.seg_start + 32'(seg.seg_length);
    exh_cur = halted_r || (bytes_free_r < 8'(PAIR_BYTES)) ||
              (ranges_emitted_r >= 3'(MAX_RANGES));
    gap         = 1'b0;
    rl_mid      = range_left_r;
    rr_mid      = range_right_r;
    re_mid      = ranges_emitted_r;
    bf_mid      = bytes_free_r;
    halted_mid  = halted_r;
    aborted_mid = aborted_r;

    if (seg.first_item) begin
      re_mid     = 3'd0;
      halted_mid = 1'b0;
      if (seg.space_bytes < 8'(HEADER_BYTES + PAIR_BYTES)) begin
        aborted_mid = 1'b1;
        bf_mid      = seg.space_bytes;
        rl_mid      = 32'd0;
        rr_mid      = 32'd0;
      end else begin
        aborted_mid = 1'b0;
        bf_mid      = seg.space_bytes - 8'(HEADER_BYTES);
        rl_mid      = seg.seg_start;
        rr_mid      = seg_end;
      end
    end else if (!aborted_r && !exh_cur) begin
      // older segment not abutting the open range: close it
      if (range_left_r != seg_end) begin
        gap    = 1'b1;
        bf_mid = bytes_free_r - 8'(PAIR_BYTES);
        re_mid = ranges_emitted_r + 3'd1;
        rr_mid = seg_end;
      end
      rl_mid = seg.seg_start;
    end

    gap_res = '{range_start: range_left_r, range_end: range_right_r, range_valid: 1'b1,
                run_done: 1'b0, composed: 1'b0, option_bytes: 8'd0, space_left: 8'd0};

    exh_mid = halted_mid || (bf_mid < 8'(PAIR_BYTES)) || (re_mid >= 3'(MAX_RANGES));
    bf_fin  = bf_mid - 8'(PAIR_BYTES);
    re_fin  = re_mid + 3'd1;

    if (aborted_mid) begin
      done_res = '{range_start: 32'd0, range_end: 32'd0, range_valid: 1'b0,
                   run_done: 1'b1, composed: 1'b0, option_bytes: 8'd0, space_left: bf_mid};
    end else if (!exh_mid) begin
      done_res = '{range_start: rl_mid, range_end: rr_mid, range_valid: 1'b1,
                   run_done: 1'b1, composed: 1'b1, option_bytes: option_len(re_fin),
                   space_left: bf_fin};
    end else begin
      done_res = '{range_start: 32'd0, range_end: 32'd0, range_valid: 1'b0,
                   run_done: 1'b1, composed: 1'b1, option_bytes: option_len(re_mid),
                   space_left: bf_mid};
    end

    range_left_nxt     = rl_mid;
    range_right_nxt    = rr_mid;
    ranges_emitted_nxt = re_mid;
    bytes_free_nxt     = bf_mid;
    halted_nxt         = halted_mid;
    aborted_nxt        = aborted_mid;
    if (seg.last_item) begin
      halted_nxt = 1'b1;
      if (!aborted_mid && !exh_mid) begin
        ranges_emitted_nxt = re_fin;
        bytes_free_nxt     = bf_fin;
      end
    end

    push.cnt = seg_vld ? ({1'b0, gap} + {1'b0, seg.last_item}) : 2'd0;
    push.r0  = gap ? gap_res : done_res;
    push.r1  = done_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_left_r     <= '0;
      range_right_r    <= '0;
      ranges_emitted_r <= '0;
      bytes_free_r     <= '0;
      halted_r         <= 1'b0;
      aborted_r        <= 1'b0;
    end else if (seg_vld) begin
      range_left_r     <= range_left_nxt;
      range_right_r    <= range_right_nxt;
      ranges_emitted_r <= ranges_emitted_nxt;
      bytes_free_r     <= bytes_free_nxt;
      halted_r         <= halted_nxt;
      aborted_r        <= aborted_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sbc_res_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_res_fifo: result queue, two writes and one read per cycle
// Takes 0..2 results per segment transfer; presents one per ready cycle.
// ----------------------------------------------------------------------------
module sbc_res_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  sbc_pkg::push_t push,
  output logic           push_ok,
  output logic           res_valid,
  input  logic           res_ready,
  output sbc_pkg::res_t  res_data
);
  import sbc_pkg::*;

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;

  // room for a worst-case segment (two results) regardless of the pop
  assign push_ok   = cnt_r <= RES_CNT_W'(RES_DEPTH - 2);
  assign res_valid = cnt_r != '0;
  assign res_data  = mem[rd_ptr_r];
  assign pop       = res_valid && res_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + RES_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sack_block_composer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sack_block_composer_core: SACK option range builder
// Merges buffered segments (newest first) into SACK ranges and reports
// the option length and remaining option space at the end of each run.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_seg    in   valid/ready (sink)   seg_start, seg_length, first/last_item,
//                                      space_bytes
//  out_res   out  valid/ready (source) range_start/end, range_valid, run_done,
//                                      composed, option_bytes, space_left
//
// One segment per cycle while in_seg.ready is high. A last segment that also
// closes a gap gives two results, drained one per cycle while out_res.ready
// is high from a 4-entry result queue; in_seg.ready drops while it holds > 2.
// Synchronous active-low reset clears the range state and the queue.
// Output stalls back up through the queue only, never into the range state.
// ----------------------------------------------------------------------------
module sack_block_composer_core #(
  parameter int unsigned MAX_RANGES = sbc_pkg::MAX_RANGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sbc_seg_if.sink   in_seg,
  sbc_res_if.source out_res
);
  import sbc_pkg::*;

  seg_t  seg;
  push_t push;
  res_t  res;
  logic  seg_xfer;
  logic  push_ok;

  assign seg = '{seg_start: in_seg.seg_start, seg_length: in_seg.seg_length,
                 first_item: in_seg.first_item, last_item: in_seg.last_item,
                 space_bytes: in_seg.space_bytes};

  assign in_seg.ready = push_ok;
  assign seg_xfer     = in_seg.valid && push_ok;

  sbc_step #(
    .MAX_RANGES (MAX_RANGES)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .seg_vld (seg_xfer),
    .seg     (seg),
    .push    (push)
  );

  sbc_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ok   (push_ok),
    .res_valid (out_res.valid),
    .res_ready (out_res.ready),
    .res_data  (res)
  );

  assign out_res.range_start  = res.range_start;
  assign out_res.range_end    = res.range_end;
  assign out_res.range_valid  = res.range_valid;
  assign out_res.run_done     = res.run_done;
  assign out_res.composed     = res.composed;
  assign out_res.option_bytes = res.option_bytes;
  assign out_res.space_left   = res.space_left;

endmodule
`default_nettype wire

/* rtl/sbc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_checker: port-level checks for the SACK block composer
// Result record consistency and output behavior around reset and stalls.
// ----------------------------------------------------------------------------
module sbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] range_start,
  input logic [31:0] range_end,
  input logic        range_valid,
  input logic        run_done,
  input logic        composed,
  input logic [7:0]  option_bytes,
  input logic [7:0]  space_left
);
  import sbc_pkg::*;

  // result queue empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(range_start) && $stable(range_end)
      && $stable(run_done) && $stable(space_left))
    else $error("stalled result changed");

  // mid-run results are plain ranges with no summary
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !run_done |-> range_valid && !composed && option_bytes == 8'd0
      && space_left == 8'd0)
    else $error("mid-run result carries summary data");

  // an aborted run reports nothing but the space; a built option is header plus pairs
  a_done_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && run_done |->
      (!composed && !range_valid && option_bytes == 8'd0) ||
      (composed && option_bytes[2:0] == 3'(HEADER_BYTES) &&
       option_bytes >= 8'(HEADER_BYTES)))
    else $error("bad done record");

endmodule

bind sack_block_composer_core sbc_checker u_sbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .range_start  (out_res.range_start),
  .range_end    (out_res.range_end),
  .range_valid  (out_res.range_valid),
  .run_done     (out_res.run_done),
  .composed     (out_res.composed),
  .option_bytes (out_res.option_bytes),
  .space_left   (out_res.space_left)
);
`default_nettype wire
